>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("check failed: same-cycle implication");
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("check failed: next-cycle implication");
`else
`define CHK_IMPLY(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/mhss_pkg.sv
// ---------------------------------------------------------------------------
// mhss_pkg
// Shared types, command codes and the half-step coil pattern.
// ---------------------------------------------------------------------------
package mhss_pkg;

	typedef logic [1:0] op_t;

	localparam op_t OP_TICK = 2'd0;
	localparam op_t OP_MOVE = 2'd1;
	localparam op_t OP_HOME = 2'd2;

	localparam logic [2:0]  IDLE_SELECT   = 3'd7;
	localparam logic [15:0] PERIOD_RESET  = 16'd1100;

	// One request as it sits in the input stage
	typedef struct packed {
		op_t         operation;
		logic [2:0]  motor;
		logic [15:0] step_count;
		logic        direction;
		logic        limit_switch;
	} item_t;

	// One result
	typedef struct packed {
		logic [3:0] coils;
		logic [2:0] motor_select;
		logic       busy_res;
		logic       done_res;
	} result_t;

	// Phase memory write port
	typedef struct packed {
		logic       en;
		logic [2:0] addr;
		logic [2:0] data;
	} phase_wr_t;

	// Coil pattern for a half-step phase, bit 3 is the first coil
	function automatic logic [3:0] half_step_coils(input logic [2:0] ph);
		logic [3:0] c;
		case (ph)
			3'd0:    c = 4'b1000;
			3'd1:    c = 4'b1100;
			3'd2:    c = 4'b0100;
			3'd3:    c = 4'b0110;
			3'd4:    c = 4'b0010;
			3'd5:    c = 4'b0011;
			3'd6:    c = 4'b0001;
			default: c = 4'b1001;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/mhss_phase_mem.sv
// ---------------------------------------------------------------------------
// mhss_phase_mem
// Per-motor half-step phase store: synchronous read, one write port,
// write-to-read bypass and reset-cleared valid bits (invalid reads as zero).
// ---------------------------------------------------------------------------
module mhss_phase_mem
	import mhss_pkg::*;
#(
	parameter int MOTORS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_en,
	input  logic [2:0] rd_addr,
	input  phase_wr_t  wr,
	output logic [2:0] rd_data
);

	localparam int AW    = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int DEPTH = 1 << AW;

	logic [2:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [2:0]       rd_data_q;
	logic [AW-1:0]    wa;
	logic [AW-1:0]    ra;

	assign wa = wr.addr[AW-1:0];
	assign ra = rd_addr[AW-1:0];

	// Write phase entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wa] <= wr.data;
		end
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wa] <= 1'b1;
		end
	end

	// Registered read, bypass a write landing on the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wa == ra)) begin
				rd_data_q <= wr.data;
			end else if (valid_q[ra]) begin
				rd_data_q <= mem_q[ra];
			end else begin
				rd_data_q <= 3'd0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/mhss_step_ctrl.sv
// ---------------------------------------------------------------------------
// mhss_step_ctrl
// Run state and step timing: decides start, step, wait or finish for the
// request in the input stage and writes the advanced phase back.
// ---------------------------------------------------------------------------
module mhss_step_ctrl
	import mhss_pkg::*;
#(
	parameter int MOTORS     = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        adv,
	input  item_t       item,
	input  logic [2:0]  phase_rd,
	output phase_wr_t   wr,
	output result_t     res
);

	logic                  active_q;
	logic                  homing_q;
	logic                  reverse_q;
	logic [2:0]            cur_motor_q;
	logic [2:0]            cur_phase_q;
	logic [COUNT_BITS-1:0] steps_left_q;
	logic [15:0]           wait_q;
	logic [3:0]            coil_q;
	logic [15:0]           period_q;

	logic                  start;
	logic                  run_home;
	logic                  run_rev;
	logic                  step_due;
	logic                  finish;
	logic                  do_step;
	logic                  active_n;
	logic [2:0]            ph;
	logic [2:0]            ph_next;
	logic [2:0]            mot;
	logic [COUNT_BITS-1:0] steps;
	logic [3:0]            coil_n;

	// Decode the request against the run state
	always_comb begin
		start    = !active_q
			&& (item.operation == OP_MOVE || item.operation == OP_HOME)
			&& ({1'b0, item.motor} < 4'(MOTORS));
		run_home = start ? (item.operation == OP_HOME) : homing_q;
		run_rev  = start ? ((item.operation == OP_HOME) || item.direction) : reverse_q;
		steps    = start ? COUNT_BITS'(item.step_count) : steps_left_q;
		step_due = start || (active_q && (wait_q <= 16'd1));
		finish   = step_due && (run_home ? item.limit_switch : (steps == '0));
		do_step  = step_due && !finish;
		ph       = start ? phase_rd : cur_phase_q;
		mot      = start ? item.motor : cur_motor_q;
		ph_next  = run_rev ? (ph - 3'd1) : (ph + 3'd1);
		active_n = !finish && (active_q || start);
		coil_n   = do_step ? half_step_coils(ph) : coil_q;
	end

	// Result for this request
	always_comb begin
		res.coils        = active_n ? coil_n : 4'd0;
		res.motor_select = active_n ? mot : IDLE_SELECT;
		res.busy_res     = active_n;
		res.done_res     = finish;
	end

	// Write back the advanced phase
	assign wr.en   = adv && do_step;
	assign wr.addr = mot;
	assign wr.data = ph_next;

	// Hold step period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// Advance run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			homing_q     <= 1'b0;
			reverse_q    <= 1'b0;
			cur_motor_q  <= IDLE_SELECT;
			cur_phase_q  <= 3'd0;
			steps_left_q <= '0;
			wait_q       <= 16'd0;
			coil_q       <= 4'd0;
		end else if (adv) begin
			active_q <= active_n;
			if (start) begin
				reverse_q <= run_rev;
				if (!finish) begin
					homing_q <= run_home;
				end
			end
			if (finish) begin
				homing_q     <= 1'b0;
				cur_motor_q  <= IDLE_SELECT;
				steps_left_q <= '0;
				wait_q       <= 16'd0;
				coil_q       <= 4'd0;
			end else if (do_step) begin
				cur_motor_q <= mot;
				cur_phase_q <= ph_next;
				coil_q      <= coil_n;
				wait_q      <= (period_q == 16'd0) ? 16'd1 : period_q;
				if (!run_home) begin
					steps_left_q <= steps - COUNT_BITS'(1);
				end
			end else if (active_q) begin
				wait_q <= wait_q - 16'd1;
			end
		end
	end

endmodule

>>> rtl/multiplexed_half_step_stepper_sequencer_unit.sv
// A request is held in the input stage and then in the output register before its result leaves.
// Throughput: one request per cycle while the result stream is not stalled; the phase store is read
// on acceptance and written back as the request moves to the output register.
// The output register lets a new request in while a result waits.
// Reset (arst_n low, asynchronous): idle, all phases zero, period 1100.
// ---------------------------------------------------------------------------
// multiplexed_half_step_stepper_sequencer_unit
// Half-step sequencer for several steppers on shared coil lines.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multiplexed_half_step_stepper_sequencer_unit
	import mhss_pkg::*;
#(
	parameter int MOTORS     = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// motor[2:0], step_count[18:3], direction[19], limit_switch[20], zero[23:21]
	input  logic [23:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// coils[3:0], motor_select[6:4], busy_res[7]
	output logic [7:0]  m_tdata,
	// done_res
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	item_t     item_s1;
	logic      valid_s1;
	result_t   out_q;
	logic      out_valid_q;
	logic      adv;
	logic      accept;
	logic [2:0] phase_rd;
	phase_wr_t phase_wr;
	result_t   res_s1;

	// Move request on when the output register is free
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation    <= s_tuser;
			item_s1.motor        <= s_tdata[2:0];
			item_s1.step_count   <= s_tdata[18:3];
			item_s1.direction    <= s_tdata[19];
			item_s1.limit_switch <= s_tdata[20];
		end
	end

	mhss_phase_mem #(
		.MOTORS(MOTORS)
	) u_phase_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (s_tdata[2:0]),
		.wr      (phase_wr),
		.rd_data (phase_rd)
	);

	mhss_step_ctrl #(
		.MOTORS     (MOTORS),
		.COUNT_BITS (COUNT_BITS)
	) u_step_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item      (item_s1),
		.phase_rd  (phase_rd),
		.wr        (phase_wr),
		.res       (res_s1)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.busy_res, out_q.motor_select, out_q.coils};
	assign m_tlast  = out_q.done_res;

	// A finished run shows the idle select and no drive
	`CHK_IMPLY(a_done_idle, out_valid_q && out_q.done_res, !out_q.busy_res && out_q.motor_select == IDLE_SELECT && out_q.coils == 4'd0)
	// An idle result never drives the coils
	`CHK_IMPLY(a_idle_dark, out_valid_q && !out_q.busy_res, out_q.coils == 4'd0)
	// A phase write comes from a step, whose result is busy
	`CHK_NEXT(a_step_busy, phase_wr.en, out_valid_q && out_q.busy_res)
	// Requests are refused only while the input stage and the output register are both occupied
	`CHK_IMPLY(a_stall_full, !s_tready, valid_s1 && out_valid_q)

endmodule

>>> test/mhss_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mhss_checker
// Watches the request, result and register ports of the stepper sequencer,
// predicts every result from its own copy of the sequencer state and
// compares the results in order as they leave.
// ---------------------------------------------------------------------------

module mhss_checker
	import mhss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// motor[2:0], step_count[18:3], direction[19], limit_switch[20], zero[23:21]
	input  logic [23:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// coils[3:0], motor_select[6:4], busy_res[7]
	input  logic [7:0]  m_tdata,
	// done_res
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatch_count,
	output int          results_owed,
	output logic        seq_idle
);

	localparam int MOTORS = 8;

	// Half-step coil patterns, phase 0 in the lowest nibble
	localparam logic [31:0] COIL_SEQ = {
		4'b1001, 4'b0001, 4'b0011, 4'b0010,
		4'b0110, 4'b0100, 4'b1100, 4'b1000
	};

	// Predicted sequencer state
	logic [2:0]  phase_mem [8];
	logic        running;
	logic        homing_run;
	logic        rev;
	logic [2:0]  sel;
	logic [15:0] steps_left;
	logic [15:0] wait_left;
	logic [3:0]  coil_now;
	logic [15:0] period;
	logic        finished;

	result_t     owed_results [$];
	item_t       req;
	result_t     got;
	result_t     want;

	task automatic clear_sequencer();
		for (int k = 0; k < 8; k++)
			phase_mem[k] = 3'd0;
		running    = 1'b0;
		homing_run = 1'b0;
		rev        = 1'b0;
		sel        = IDLE_SELECT;
		steps_left = 16'd0;
		wait_left  = 16'd0;
		coil_now   = 4'd0;
		period     = PERIOD_RESET;
	endtask

	// Drive the pattern of the current phase, then move the phase on by one
	task automatic take_half_step();
		logic [2:0] ph;
		ph = phase_mem[sel];
		coil_now = COIL_SEQ[ph*4 +: 4];
		phase_mem[sel] = rev ? ph - 3'd1 : ph + 3'd1;
		wait_left = (period == 16'd0) ? 16'd1 : period;
	endtask

	task automatic finish_run();
		running    = 1'b0;
		homing_run = 1'b0;
		coil_now   = 4'd0;
		sel        = IDLE_SELECT;
		wait_left  = 16'd0;
		steps_left = 16'd0;
		finished   = 1'b1;
	endtask

	task automatic advance_run(input logic limit);
		if (homing_run) begin
			if (limit)
				finish_run();
			else
				take_half_step();
		end else if (steps_left == 16'd0) begin
			finish_run();
		end else begin
			take_half_step();
			steps_left = steps_left - 16'd1;
		end
	endtask

	// Work out the result that one accepted request causes
	task automatic sequence_item(input item_t it, output result_t res);
		finished = 1'b0;
		if (!running && (it.operation == OP_MOVE || it.operation == OP_HOME)
				&& int'(it.motor) < MOTORS) begin
			running = 1'b1;
			sel = it.motor;
			if (it.operation == OP_MOVE) begin
				homing_run = 1'b0;
				rev = it.direction;
				steps_left = it.step_count;
			end else begin
				homing_run = 1'b1;
				rev = 1'b1;
			end
			advance_run(it.limit_switch);
		end else if (running) begin
			if (wait_left > 16'd1)
				wait_left = wait_left - 16'd1;
			else
				advance_run(it.limit_switch);
		end
		res.coils        = running ? coil_now : 4'd0;
		res.motor_select = running ? sel : IDLE_SELECT;
		res.busy_res     = running;
		res.done_res     = finished;
	endtask

	// Track register writes, check results, then predict the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sequencer();
			owed_results.delete();
			mismatch_count = 0;
			results_owed <= 0;
			seq_idle <= 1'b1;
		end else begin
			if (cfg_we)
				period = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got = {m_tdata[3:0], m_tdata[6:4], m_tdata[7], m_tlast};
				if (owed_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("%t: result %h arrived with no request owed", $realtime, got);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$write("%t: result mismatch: coils %b/%b select %0d/%0d ",
								$realtime, want.coils, got.coils,
								want.motor_select, got.motor_select);
							$display("busy %b/%b done %b/%b (expected/actual)",
								want.busy_res, got.busy_res, want.done_res, got.done_res);
						end
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req = {s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[19], s_tdata[20]};
				sequence_item(req, want);
				owed_results.push_back(want);
			end
			results_owed <= owed_results.size();
			seq_idle <= !running;
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the multiplexed half-step stepper sequencer: directed moves
// and homing runs at the reset period and the period extremes, then random
// well-formed runs mixed with stray commands, under random stalls on both
// streams. The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------

module tb
	import mhss_pkg::*;
();

	localparam op_t OP_SPARE   = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 8;
	localparam int PHASE_ITEMS = 280;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	int          mismatch_count;
	int          results_owed;
	logic        seq_idle;

	int          cycle_count = 0;
	int          requests_sent = 0;
	int          moves_started = 0;
	int          homings_started = 0;
	int          periods_tried = 1;
	int          eff_period = int'(PERIOD_RESET);
	int          gap_pct = 15;
	int          stall_pct = 10;
	logic        was_idle = 1'b1;

	multiplexed_half_step_stepper_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mhss_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.seq_idle       (seq_idle)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multiplexed_half_step_stepper_sequencer_unit verification failed");
			$finish;
		end
	end

	// Stall the result stream in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one request, hold it until taken; note whether the sequencer
	// was idle before it
	task automatic send_request(input op_t op, input logic [2:0] motor,
			input logic [15:0] count, input logic dir, input logic limit);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, limit, dir, count, motor};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		was_idle = seq_idle;
		requests_sent++;
	endtask

	task automatic tick(input logic limit);
		op_t op;
		op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OP_TICK;
		send_request(op, 3'($urandom), 16'($urandom), 1'($urandom), limit);
	endtask

	// Ticks of a run in progress; stray commands are dropped by the block.
	// For homing the switch is low on every step tick but the last.
	task automatic busy_ticks(input int n, input bit homing_mode);
		logic limit;
		op_t  op;
		for (int t = 1; t <= n; t++) begin
			if (homing_mode && t % eff_period == 0)
				limit = (t == n);
			else
				limit = 1'($urandom);
			if ($urandom_range(0, 99) < 6) begin
				op = $urandom_range(0, 1) ? OP_MOVE : OP_HOME;
				send_request(op, 3'($urandom), 16'($urandom), 1'($urandom), limit);
			end else begin
				tick(limit);
			end
		end
		repeat ($urandom_range(0, 3)) tick(1'($urandom));
	endtask

	task automatic counted_run(input logic [2:0] motor, input logic [15:0] count,
			input logic dir);
		moves_started++;
		send_request(OP_MOVE, motor, count, dir, 1'($urandom));
		busy_ticks(int'(count) * eff_period, 1'b0);
	endtask

	task automatic homing_run(input logic [2:0] motor, input int steps);
		homings_started++;
		send_request(OP_HOME, motor, 16'($urandom), 1'($urandom), steps == 0);
		busy_ticks(steps * eff_period, 1'b1);
	endtask

	// Stray commands, then tick with the switch high until the run ends
	task automatic noise_burst();
		repeat ($urandom_range(1, 6))
			send_request(op_t'($urandom_range(0, 3)), 3'($urandom),
				16'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
		do
			tick(1'b1);
		while (!was_idle);
	endtask

	task automatic random_runs(input int budget);
		int first;
		int pick;
		first = requests_sent;
		while (requests_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				counted_run(3'($urandom),
					($urandom_range(0, 4) == 0) ? 16'($urandom_range(13, 48))
						: 16'($urandom_range(0, 12)), 1'($urandom));
			else if (pick < 85)
				homing_run(3'($urandom),
					($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
			else
				noise_burst();
		end
	endtask

	// Hold requests until every owed result has left
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_period(input logic [15:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		eff_period = (value == 16'd0) ? 1 : int'(value);
		periods_tried++;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset period: plain and spare ticks, zero count, switch already high
		send_request(OP_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
		send_request(OP_SPARE, 3'd7, 16'hFFFF, 1'b1, 1'b1);
		counted_run(3'd0, 16'd0, 1'b0);
		homing_run(3'd7, 0);

		// Shortest period: a long count backwards, then short runs
		set_period(16'd1);
		gap_pct = 0;
		stall_pct = 0;
		counted_run(3'd2, 16'd40, 1'b1);
		gap_pct = 15;
		stall_pct = 10;
		counted_run(3'd6, 16'd3, 1'b0);
		homing_run(3'd5, 3);

		// Zero period behaves as one
		set_period(16'd0);
		random_runs(PHASE_ITEMS);

		set_period(16'd3);
		random_runs(PHASE_ITEMS / 2);
		gap_pct = 0;
		stall_pct = 0;
		random_runs(PHASE_ITEMS / 2);

		// Longest period: runs that end on their start request
		set_period(16'hFFFF);
		counted_run(3'd3, 16'd0, 1'b0);
		homing_run(3'd3, 0);

		set_period(16'($urandom_range(4, 7)));
		gap_pct = 25;
		stall_pct = 25;
		random_runs(PHASE_ITEMS);

		set_period(16'd2);
		gap_pct = 10;
		stall_pct = 10;
		random_runs(PHASE_ITEMS);

		// Closing stretch at full rate
		set_period(16'd1);
		gap_pct = 0;
		stall_pct = 0;
		random_runs(PHASE_ITEMS);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests over %0d step periods, extremes included.",
			requests_sent, periods_tried);
		$display("It started %0d counted moves and %0d homing runs; %0d results disagreed.",
			moves_started, homings_started, mismatch_count);
		if (mismatch_count == 0)
			$display("multiplexed_half_step_stepper_sequencer_unit verification clean");
		else
			$display("multiplexed_half_step_stepper_sequencer_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/mhss_pkg.sv
rtl/mhss_phase_mem.sv
rtl/mhss_step_ctrl.sv
rtl/multiplexed_half_step_stepper_sequencer_unit.sv
test/mhss_checker.sv
test/tb.sv
